@@ rtl/ppi_pkg.sv @@
// Shared operation codes, status codes and control structs for the point-in-polygon block.
package ppi_pkg;

    // Request operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_OVR   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_TEST  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    // Smallest polygon that can be tested
    localparam int MIN_VERTICES = 3;

    // Coordinate width (24.8 fixed point)
    localparam int COORD_W = 32;

    // Walk control from the sequencer to the edge unit
    typedef struct packed {
        logic start;      // clear parity for a new test
        logic vtx_valid;  // memory read data holds a vertex
        logic vtx_first;  // wrap vertex (last one), opens the first edge
        logic vtx_last;   // final vertex of the walk
    } ppi_edge_ctl_t;

    // Edge unit status back to the sequencer
    typedef struct packed {
        logic done;       // all edges have been folded into parity
        logic parity;     // even-odd inside flag
    } ppi_edge_sts_t;

endpackage

@@ rtl/ppi_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module ppi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/ppi_edge_unit.sv @@
// Edge crossing pipeline: forms edges from streamed vertices and folds crossings into parity.
module ppi_edge_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ppi_pkg::ppi_edge_ctl_t        ctl,
    input  logic signed [ppi_pkg::COORD_W-1:0] pt_x,
    input  logic signed [ppi_pkg::COORD_W-1:0] pt_y,
    input  logic [2*ppi_pkg::COORD_W-1:0] vtx_data,
    output ppi_pkg::ppi_edge_sts_t        sts
);

    import ppi_pkg::*;

    localparam int DW = COORD_W + 1;
    localparam int PW = 2 * DW;

    logic signed [COORD_W-1:0] cur_x, cur_y;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;

    // Stage 1: differences
    logic                 s1_valid_reg, s1_last_reg, s1_straddle_reg;
    logic signed [DW-1:0] s1_a_reg, s1_dy_reg, s1_c_reg, s1_d_reg;
    // Stage 2: products
    logic                 s2_valid_reg, s2_last_reg, s2_straddle_reg, s2_dypos_reg;
    logic signed [PW-1:0] s2_l_reg, s2_r_reg;
    // Stage 3: parity
    logic                 parity_reg, done_reg;
    logic                 crossing;

    assign cur_x = vtx_data[2*COORD_W-1:COORD_W];
    assign cur_y = vtx_data[COORD_W-1:0];

    // Previous vertex (j) register
    always_ff @(posedge aclk) begin
        if (ctl.vtx_valid) begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
    end

    // Stage 1: edge from vertex i (current) to j (previous)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= ctl.vtx_valid && !ctl.vtx_first;
            s1_last_reg  <= ctl.vtx_valid && ctl.vtx_last;
        end
        s1_straddle_reg <= (cur_y > pt_y) != (prev_y_reg > pt_y);
        s1_a_reg        <= DW'(pt_x) - DW'(cur_x);
        s1_dy_reg       <= DW'(prev_y_reg) - DW'(cur_y);
        s1_c_reg        <= DW'(prev_x_reg) - DW'(cur_x);
        s1_d_reg        <= DW'(pt_y) - DW'(cur_y);
    end

    // Stage 2: cross products (dy is never zero on a straddling edge)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
        end
        s2_straddle_reg <= s1_straddle_reg;
        s2_dypos_reg    <= !s1_dy_reg[DW-1] && (s1_dy_reg != '0);
        s2_l_reg        <= PW'(s1_a_reg) * PW'(s1_dy_reg);
        s2_r_reg        <= PW'(s1_c_reg) * PW'(s1_d_reg);
    end

    // Comparison direction follows the sign of dy
    assign crossing = s2_dypos_reg ? (s2_l_reg < s2_r_reg) : (s2_r_reg < s2_l_reg);

    // Stage 3: parity accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= s2_valid_reg && s2_last_reg;
            if (ctl.start) begin
                parity_reg <= 1'b0;
            end else if (s2_valid_reg && s2_straddle_reg && crossing) begin
                parity_reg <= !parity_reg;
            end
        end
    end

    assign sts.done   = done_reg;
    assign sts.parity = parity_reg;

endmodule

@@ rtl/polygon_point_inclusion.sv @@
// Polygon store and even-odd point-in-polygon test, top level with request sequencer.
// Vertices live in one MAX_VERTICES x 64-bit RAM. Add, overwrite and clear requests pass
// from accept through the S_DONE state into the output register. A point test with n >= 3
// vertices reads the RAM once per vertex (n + 1 reads, the last vertex first to close the
// polygon), and the single RAM read port sets its length.
// A test with fewer than three vertices answers like an add, through S_DONE, with status "too few". The
// result sits in an output register, so the next request is accepted while it waits.
module polygon_point_inclusion #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_op,
    input  logic signed [ppi_pkg::COORD_W-1:0]  s_coord_x,
    input  logic signed [ppi_pkg::COORD_W-1:0]  s_coord_y,
    input  logic [5:0]                          s_vertex_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_inside_res,
    output logic [1:0]                          m_status,
    output logic [$clog2(MAX_VERTICES+1)-1:0]   m_vertex_count
);

    import ppi_pkg::*;

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic signed [COORD_W-1:0] pt_x_reg, pt_x_next, pt_y_reg, pt_y_next;
    logic               res_inside_reg, res_inside_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               vtx_valid_reg, vtx_valid_next;
    logic               vtx_first_reg, vtx_first_next;
    logic               vtx_last_reg, vtx_last_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_inside_reg, m_inside_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [CNT_W-1:0]   m_count_reg, m_count_next;

    logic               accept, full, idx_ok;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [2*COORD_W-1:0] rd_data;
    ppi_edge_ctl_t      edge_ctl;
    ppi_edge_sts_t      edge_sts;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign full    = (total_reg == CNT_W'(MAX_VERTICES));
    assign idx_ok  = CMP_W'(s_vertex_index) < CMP_W'(total_reg);

    // Vertex writes happen in the accept cycle
    assign wr_en   = accept && (((s_op == OP_ADD) && !full) || ((s_op == OP_OVR) && idx_ok));
    assign wr_addr = (s_op == OP_ADD) ? total_reg[AW-1:0] : AW'(s_vertex_index);

    ppi_ram #(
        .WIDTH(2 * COORD_W),
        .DEPTH(MAX_VERTICES)
    ) u_vtx_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({s_coord_x, s_coord_y}),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // Control to the edge pipeline, aligned with read data
    assign edge_ctl.start     = accept && (s_op == OP_TEST);
    assign edge_ctl.vtx_valid = vtx_valid_reg;
    assign edge_ctl.vtx_first = vtx_first_reg;
    assign edge_ctl.vtx_last  = vtx_last_reg;

    ppi_edge_unit u_edge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (edge_ctl),
        .pt_x     (pt_x_reg),
        .pt_y     (pt_y_reg),
        .vtx_data (rd_data),
        .sts      (edge_sts)
    );

    // Sequencer next-state logic
    always_comb begin
        state_next      = state_reg;
        total_next      = total_reg;
        step_next       = step_reg;
        addr_next       = addr_reg;
        pt_x_next       = pt_x_reg;
        pt_y_next       = pt_y_reg;
        res_inside_next = res_inside_reg;
        res_status_next = res_status_reg;
        vtx_valid_next  = 1'b0;
        vtx_first_next  = 1'b0;
        vtx_last_next   = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;
        m_inside_next   = m_inside_reg;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_inside_next = 1'b0;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    case (s_op)
                        OP_ADD: begin
                            if (full) begin
                                res_status_next = ST_FULL;
                            end else begin
                                total_next = total_reg + 1'b1;
                            end
                        end
                        OP_OVR: begin
                            if (!idx_ok) begin
                                res_status_next = ST_BAD;
                            end
                        end
                        OP_CLEAR: begin
                            total_next = '0;
                        end
                        default: begin
                            if (total_reg < CNT_W'(MIN_VERTICES)) begin
                                res_status_next = ST_FEW;
                            end else begin
                                // Start with the last vertex to close the polygon
                                state_next = S_WALK;
                                step_next  = '0;
                                addr_next  = AW'(total_reg - 1'b1);
                                pt_x_next  = s_coord_x;
                                pt_y_next  = s_coord_y;
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                vtx_valid_next = 1'b1;
                vtx_first_next = (step_reg == '0);
                vtx_last_next  = (step_reg == total_reg);
                addr_next      = (step_reg == '0) ? '0 : addr_reg + 1'b1;
                step_next      = step_reg + 1'b1;
                if (step_reg == total_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (edge_sts.done) begin
                    res_inside_next = edge_sts.parity;
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_inside_next = res_inside_reg;
                    m_status_next = res_status_reg;
                    m_count_next  = total_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            step_reg       <= '0;
            addr_reg       <= '0;
            vtx_valid_reg  <= 1'b0;
            vtx_first_reg  <= 1'b0;
            vtx_last_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            res_inside_reg <= 1'b0;
            res_status_reg <= ST_OK;
            m_inside_reg   <= 1'b0;
            m_status_reg   <= ST_OK;
            m_count_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            step_reg       <= step_next;
            addr_reg       <= addr_next;
            vtx_valid_reg  <= vtx_valid_next;
            vtx_first_reg  <= vtx_first_next;
            vtx_last_reg   <= vtx_last_next;
            m_valid_reg    <= m_valid_next;
            res_inside_reg <= res_inside_next;
            res_status_reg <= res_status_next;
            m_inside_reg   <= m_inside_next;
            m_status_reg   <= m_status_next;
            m_count_reg    <= m_count_next;
        end
        pt_x_reg <= pt_x_next;
        pt_y_reg <= pt_y_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_inside_res   = m_inside_reg;
    assign m_status       = m_status_reg;
    assign m_vertex_count = m_count_reg;

endmodule

@@ rtl/ppi_checker.sv @@
// Port-level checks for the point-in-polygon block, bound to the top level.
module ppi_checker #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_inside_res,
    input  logic [1:0]                          m_status,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]   m_vertex_count
);

    import ppi_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    // A stalled result stays
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_status) && $stable(m_vertex_count)
                                && $stable(m_inside_res))
        else $error("stalled result changed");

    // A refused add only happens with a full store
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL) |-> m_vertex_count == CNT_W'(MAX_VERTICES))
        else $error("store-full status with room left");

    // Inside only on a good test of a real polygon
    a_inside_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_inside_res |->
            (m_status == ST_OK) && (m_vertex_count >= CNT_W'(MIN_VERTICES)))
        else $error("inside flag on a refused or degenerate test");

    // Too-few status only below three vertices
    a_few_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FEW) |-> m_vertex_count < CNT_W'(MIN_VERTICES))
        else $error("too-few status with a full polygon");

endmodule

bind polygon_point_inclusion ppi_checker #(.MAX_VERTICES(MAX_VERTICES)) u_ppi_checker (.*);
